@@ hw/rtl/lpre_pkg.sv @@
// Shared types and constants for the length-prefixed record extractor.
// No dependencies; compiled first.
package lpre_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int BYTE_W          = 8;
  localparam int REG_W           = 16;
  localparam int REG_IDX_W       = 2;
  localparam int ERR_W           = 2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_HEADER = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRE    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_POST   = 2'd2;

  // Error codes on the result channel
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SHORT_LEN = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED = 2'd2;

  // Smallest legal record length: one tag byte plus two length bytes
  localparam logic [REG_W-1:0] MIN_REC_LEN = 16'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PRE    = 2'd1,
    PH_RECORD = 2'd2,
    PH_POST   = 2'd3
  } phase_t;

endpackage

@@ hw/rtl/lpre_if.sv @@
// Valid/ready channel interfaces for the record extractor.
// Depends on lpre_pkg for field widths.
interface lpre_in_if;
  import lpre_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              stream_end;

  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface lpre_out_if;
  import lpre_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] record_byte;
  logic              record_last;
  logic [ERR_W-1:0]  error_code;

  modport source (output valid, record_byte, record_last, error_code, input ready);
  modport sink   (input valid, record_byte, record_last, error_code, output ready);
endinterface

@@ hw/rtl/length_prefixed_record_extractor.sv @@
// Length-prefixed record extractor, top level.
// Depends on lpre_pkg and the channel interfaces in lpre_if.sv.
//
// Usage:
//   byte_in carries one stream byte per transaction plus stream_end, which
//   flags the last byte of a stream. rec_out carries each byte that belongs
//   to a record, with record_last on the final byte of the record and an
//   error code (short length field, or stream ended mid-record). The user
//   is to set the header, pre and post skip byte counts via the write port
//   (cfg_we/cfg_index/cfg_data) while idle; the block does not check.
// Timing:
//   One byte accepted per cycle unless rec_out stalls. A record byte shows
//   up on rec_out in the cycle after its input transaction. The rate is set
//   by the combinational phase/count update feeding the output register.
// Stall:
//   When rec_out holds a result that is not taken, byte_in.ready drops
//   until it is; skipped bytes are taken freely while the output is empty.
// Reset:
//   rst (synchronous) clears the skip registers to 0, returns to header
//   phase with zero count and length, and empties the output register.
module length_prefixed_record_extractor #(
  parameter int COUNT_WIDTH = lpre_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lpre_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [lpre_pkg::REG_W-1:0]    cfg_data,
  lpre_in_if.sink                       byte_in,
  lpre_out_if.source                    rec_out
);
  import lpre_pkg::*;

  logic [REG_W-1:0]       header_length;
  logic [REG_W-1:0]       pre_length;
  logic [REG_W-1:0]       post_length;

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] byte_count, byte_count_next;
  logic [REG_W-1:0]       record_length, record_length_next;

  logic                   out_valid;
  logic [BYTE_W-1:0]      out_byte;
  logic                   out_last;
  logic [ERR_W-1:0]       out_err;

  logic                   emit;
  logic                   last_c;
  logic [ERR_W-1:0]       err_c;
  logic                   accept;

  assign byte_in.ready = !out_valid || rec_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;

  assign rec_out.valid       = out_valid;
  assign rec_out.record_byte = out_byte;
  assign rec_out.record_last = out_last;
  assign rec_out.error_code  = out_err;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      header_length <= '0;
      pre_length    <= '0;
      post_length   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER: header_length <= cfg_data;
        REG_PRE:    pre_length    <= cfg_data;
        REG_POST:   post_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_t                 ph;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [REG_W-1:0]       rl;
    logic                   short_len;

    ph        = phase;
    cnt       = byte_count;
    rl        = record_length;
    short_len = 1'b0;
    emit      = 1'b0;
    last_c    = 1'b0;
    err_c     = ERR_NONE;

    // Exhausted skip phases fall through before the byte is handled
    if (ph == PH_HEADER && cnt >= COUNT_WIDTH'(header_length)) begin
      ph  = PH_PRE;
      cnt = '0;
    end
    if (ph == PH_POST && cnt >= COUNT_WIDTH'(post_length)) begin
      ph  = PH_PRE;
      cnt = '0;
    end
    if (ph == PH_PRE && cnt >= COUNT_WIDTH'(pre_length)) begin
      ph  = PH_RECORD;
      cnt = '0;
    end

    cnt_inc = (cnt == '1) ? cnt : cnt + 1'b1;

    if (ph == PH_RECORD) begin
      emit = 1'b1;
      if (cnt == COUNT_WIDTH'(1)) begin
        rl = {byte_in.data_byte, 8'h00};
      end else if (cnt >= COUNT_WIDTH'(2)) begin
        if (cnt == COUNT_WIDTH'(2)) begin
          rl        = {record_length[REG_W-1:BYTE_W], byte_in.data_byte};
          short_len = rl < MIN_REC_LEN;
        end
        last_c = short_len ||
                 ((COUNT_WIDTH+1)'(cnt) + 1'b1 >= (COUNT_WIDTH+1)'(rl));
      end
      if (short_len) err_c = ERR_SHORT_LEN;
      if (last_c) begin
        ph  = PH_POST;
        cnt = '0;
      end else begin
        cnt = cnt_inc;
        if (byte_in.stream_end) begin
          last_c = 1'b1;
          err_c  = ERR_TRUNCATED;
        end
      end
    end else begin
      cnt = cnt_inc;
    end

    if (byte_in.stream_end) begin
      ph  = PH_HEADER;
      cnt = '0;
      rl  = '0;
    end

    phase_next         = ph;
    byte_count_next    = cnt;
    record_length_next = rl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_count    <= '0;
      record_length <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      record_length <= record_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (rec_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte <= byte_in.data_byte;
      out_last <= last_c;
      out_err  <= err_c;
    end
  end

endmodule

@@ hw/rtl/lpre_checker.sv @@
// Port-level checks for the record extractor, bound to the top level.
// Depends on lpre_pkg for widths and error codes.
module lpre_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lpre_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_last,
  input logic [lpre_pkg::ERR_W-1:0] out_err
);
  import lpre_pkg::*;

  // Only defined error codes leave the block
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_err == ERR_NONE || out_err == ERR_SHORT_LEN ||
                   out_err == ERR_TRUNCATED))
    else $error("undefined error code");

  // Any error terminates the record
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err != ERR_NONE |-> out_last)
    else $error("error without record_last");

  // Input is held off exactly while a result is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output stall");

  // A stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_err))
    else $error("stalled result changed");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind length_prefixed_record_extractor lpre_checker u_lpre_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (byte_in.ready),
  .out_valid (rec_out.valid),
  .out_ready (rec_out.ready),
  .out_byte  (rec_out.record_byte),
  .out_last  (rec_out.record_last),
  .out_err   (rec_out.error_code)
);

@@ bench/testbench.sv @@
// Self-checking bench for length_prefixed_record_extractor: streams of skip and
// record bytes go in, every record byte out is checked against a local model.
// Needs lpre_pkg, lpre_if.sv and the extractor RTL.
module testbench;
  import lpre_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_PRINTS  = 40;
  localparam int PER_MODE    = 440;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [ERR_W-1:0]  err;
  } rec_byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              fin;
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  lpre_in_if  byte_ch ();
  lpre_out_if rec_ch ();

  length_prefixed_record_extractor uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_in   (byte_ch),
    .rec_out   (rec_ch)
  );

  // Local copy of the skip registers and the extractor state
  logic [REG_W-1:0] hdr_len   = '0;
  logic [REG_W-1:0] pre_len   = '0;
  logic [REG_W-1:0] post_len  = '0;
  phase_t           cur_phase = PH_HEADER;
  logic [REG_W-1:0] phase_cnt = '0;
  logic [REG_W-1:0] rec_len   = '0;

  rec_byte_t    rec_bytes_due[$];
  stream_byte_t stream_q[$];

  int errors = 0;
  int bytes_in = 0;
  int bytes_out = 0;
  int bytes_predicted = 0;
  int reg_writes = 0;
  int streams_sent = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Advance the local extractor by one accepted byte; queue the record byte it emits
  task automatic extract_byte(input logic [BYTE_W-1:0] b, input logic fin);
    logic             done;
    logic [ERR_W-1:0] code;
    if (cur_phase == PH_HEADER && phase_cnt >= hdr_len) begin
      cur_phase = PH_PRE;
      phase_cnt = '0;
    end
    if (cur_phase == PH_POST && phase_cnt >= post_len) begin
      cur_phase = PH_PRE;
      phase_cnt = '0;
    end
    if (cur_phase == PH_PRE && phase_cnt >= pre_len) begin
      cur_phase = PH_RECORD;
      phase_cnt = '0;
    end
    if (cur_phase == PH_RECORD) begin
      done = 1'b0;
      code = ERR_NONE;
      if (phase_cnt == 1) begin
        rec_len = {b, 8'h00};
      end else if (phase_cnt >= 2) begin
        if (phase_cnt == 2) begin
          rec_len[7:0] = b;
          if (rec_len < MIN_REC_LEN) code = ERR_SHORT_LEN;
        end
        if (code != ERR_NONE || {1'b0, phase_cnt} + 17'd1 >= {1'b0, rec_len}) done = 1'b1;
      end
      if (done) begin
        cur_phase = PH_POST;
        phase_cnt = '0;
      end else begin
        if (phase_cnt != '1) phase_cnt++;
        if (fin) begin
          done = 1'b1;
          code = ERR_TRUNCATED;
        end
      end
      rec_bytes_due.push_back({b, done, code});
      bytes_predicted++;
    end else if (phase_cnt != '1) begin
      phase_cnt++;
    end
    if (fin) begin
      cur_phase = PH_HEADER;
      phase_cnt = '0;
      rec_len   = '0;
    end
  endtask

  // Checks output transactions, then feeds input transactions to the model
  always @(posedge clk) begin
    rec_byte_t want;
    if (!rst) begin
      if (rec_ch.valid && rec_ch.ready) begin
        bytes_out++;
        if (rec_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected record byte %02h", rec_ch.record_byte));
        end else begin
          want = rec_bytes_due.pop_front();
          if (rec_ch.record_byte !== want.data)
            report_mismatch($sformatf("record_byte %02h, expected %02h",
                                      rec_ch.record_byte, want.data));
          if (rec_ch.record_last !== want.last)
            report_mismatch($sformatf("record_last %b, expected %b (byte %02h)",
                                      rec_ch.record_last, want.last, want.data));
          if (rec_ch.error_code !== want.err)
            report_mismatch($sformatf("error_code %0d, expected %0d (byte %02h)",
                                      rec_ch.error_code, want.err, want.data));
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        bytes_in++;
        extract_byte(byte_ch.data_byte, byte_ch.stream_end);
      end
    end
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (rec_ch.valid && rec_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, rec_bytes_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls plus an optional long hold-off
  initial begin
    rec_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rec_ch.ready <= 1'b0;
      end else begin
        rec_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      byte_ch.valid <= 1'b0;
    end
    @(negedge clk);
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= b;
    byte_ch.stream_end <= fin;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  // Drops valid, then waits for every outstanding record byte plus the pipeline
  task automatic wait_drained();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (rec_bytes_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    cfg_we        <= 1'b1;
    cfg_index     <= idx;
    cfg_data      <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      REG_HEADER: hdr_len  = val;
      REG_PRE:    pre_len  = val;
      REG_POST:   post_len = val;
      default: ;
    endcase
  endtask

  task automatic add_skip(input int n);
    for (int i = 0; i < n; i++) stream_q.push_back({8'($urandom), 1'b0});
  endtask

  // Tag byte, big-endian length, then body; nbytes may stop short of the length
  task automatic add_record(input int len_field, input int nbytes);
    logic [15:0] lf;
    lf = len_field[15:0];
    for (int i = 0; i < nbytes; i++) begin
      case (i)
        1:       stream_q.push_back({lf[15:8], 1'b0});
        2:       stream_q.push_back({lf[7:0], 1'b0});
        default: stream_q.push_back({8'($urandom), 1'b0});
      endcase
    end
  endtask

  task automatic send_items(input bit close);
    if (close && stream_q.size() > 0) stream_q[$].fin = 1'b1;
    foreach (stream_q[i]) send_byte(stream_q[i].data, stream_q[i].fin);
    stream_q.delete();
    streams_sent++;
  endtask

  function automatic int pick_skip();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom_range(0, 2);
    if (r < 12) return $urandom_range(13, 300);
    return $urandom_range(3, 12);
  endfunction

  task automatic test_directed();
    // default skips are all zero: records back to back
    add_record(3, 3);
    stream_q[0].data = 8'h00;
    add_record(0, 3);             // zero length field
    stream_q[3].data = 8'hFF;
    add_record(2, 3);             // length just below the minimum
    add_record(4, 4);             // stream ends exactly on the last byte
    stream_q[12].data = 8'hFF;
    send_items(1);
    add_record(5, 1);             // stream ends on the tag byte
    send_items(1);
    add_record(1, 3);             // short length and stream end together
    send_items(1);
    add_record(16'hFFFF, 4);      // truncated long record
    send_items(1);
    wait_drained();
    write_reg(REG_HEADER, 16'd2);
    write_reg(REG_PRE, 16'd1);
    write_reg(REG_POST, 16'd1);
    add_skip(3);
    add_record(3, 3);
    add_skip(1);                  // stream ends in the post skip: no result
    send_items(1);
    wait_drained();
  endtask

  task automatic test_mid_phase_config();
    write_reg(REG_HEADER, 16'd6);
    write_reg(REG_PRE, 16'd0);
    write_reg(REG_POST, 16'd0);
    add_skip(3);
    send_items(0);
    wait_drained();
    // count already past the new header length: next byte starts a record
    write_reg(REG_HEADER, 16'd2);
    write_reg(REG_UNUSED, 16'hFFFF);
    add_record(3, 3);
    add_record(4, 4);
    send_items(1);
    wait_drained();
  endtask

  task automatic test_random_streams(input int target);
    int sent;
    int kind;
    int nrec;
    int len;
    int nbytes;
    bit cut;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 25) begin
        wait_drained();
        write_reg(REG_HEADER, 16'(pick_skip()));
        write_reg(REG_PRE, 16'(pick_skip()));
        write_reg(REG_POST, 16'(pick_skip()));
        if ($urandom_range(9) == 0) write_reg(REG_UNUSED, 16'($urandom));
      end
      kind = $urandom_range(99);
      if (kind < 8) begin
        // noise, with stray stream ends
        nbytes = $urandom_range(1, 24);
        for (int i = 0; i < nbytes; i++)
          stream_q.push_back({8'($urandom), ($urandom_range(15) == 0)});
        sent += stream_q.size();
        send_items(1);
      end else begin
        add_skip(hdr_len);
        nrec = $urandom_range(1, 4);
        for (int r = 0; r < nrec; r++) begin
          add_skip(pre_len);
          len = pick_length();
          cut = (r == nrec - 1) && kind < 25;
          if (len < 3) nbytes = cut ? $urandom_range(1, 2) : 3;
          else nbytes = cut ? $urandom_range(1, len - 1) : len;
          add_record(len, nbytes);
          if (!cut) add_skip(post_len);
        end
        // a few streams stay open so later settings land mid-phase
        sent += stream_q.size();
        send_items(kind >= 12);
      end
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    write_reg(REG_HEADER, 16'd0);
    write_reg(REG_PRE, 16'd0);
    write_reg(REG_POST, 16'd1);
    hold_left = 400;
    for (int r = 0; r < 8; r++) begin
      add_record(20, 20);
      add_skip(1);
    end
    send_items(1);
    wait_drained();
  endtask

  task automatic test_skip_extremes();
    wait_drained();
    // largest skip settings: a short stream never leaves the skip phases
    write_reg(REG_HEADER, 16'hFFFF);
    write_reg(REG_PRE, 16'd0);
    write_reg(REG_POST, 16'd0);
    add_skip(40);
    send_items(1);
    wait_drained();
    write_reg(REG_HEADER, 16'd0);
    write_reg(REG_PRE, 16'hFFFF);
    write_reg(REG_POST, 16'hFFFF);
    add_skip(30);
    send_items(1);
    wait_drained();
    write_reg(REG_PRE, 16'd0);
    write_reg(REG_POST, 16'd0);
    add_record(200, 200);
    send_items(1);
    wait_drained();
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = '0;
    byte_ch.stream_end = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 26;
    snk_idle_pct = 68;
    test_directed();
    test_mid_phase_config();
    test_random_streams(PER_MODE);

    src_idle_pct = 68;
    snk_idle_pct = 26;
    test_backpressure();
    test_random_streams(PER_MODE);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_streams(PER_MODE);
    test_skip_extremes();

    wait_drained();
    repeat (5) @(posedge clk);
    $display("%0d streams, %0d bytes in, %0d record bytes checked, %0d register writes",
             streams_sent, bytes_in, bytes_out, reg_writes);
    $display("covered short and truncated records, mid-phase setting changes, skip extremes");
    if (errors == 0 && rec_bytes_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, rec_bytes_due.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/lpre_pkg.sv
hw/rtl/lpre_if.sv
hw/rtl/length_prefixed_record_extractor.sv
hw/rtl/lpre_checker.sv
bench/testbench.sv
